FILE: hdl/pmarc_pkg.sv
// Package for the PMA region checker: request codes, FSM states,
// controller/datapath command and status structs, attribute helpers. No dependencies.
package pmarc_pkg;

  localparam int unsigned MaxRegionsDefault = 16;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_REMOVE,
    ST_LOOKUP,
    ST_DONE
  } state_e;

  // Attribute bit positions.
  localparam int unsigned AttrR  = 0;
  localparam int unsigned AttrW  = 1;
  localparam int unsigned AttrX  = 2;
  localparam int unsigned AttrA  = 3;
  localparam int unsigned AttrC  = 4;
  localparam int unsigned AttrD  = 5;
  localparam int unsigned AttrIc = 6;
  localparam int unsigned AttrDc = 7;

  localparam logic [7:0] CacheBits = 8'hD0;

  localparam logic [1:0] TypeNormal   = 2'd0;
  localparam logic [1:0] TypeDevice   = 2'd1;
  localparam logic [1:0] TypeReserved = 2'd3;

  localparam logic [2:0] PolWriteBack   = 3'd0;
  localparam logic [2:0] PolWriteThru   = 3'd1;
  localparam logic [2:0] PolUncached    = 3'd3;
  localparam logic [2:0] PolUncacheable = 3'd4;

  typedef struct packed {
    logic       cap;         // capture request fields
    logic       wr_en;
    logic       wr_new;      // write the captured region instead of the read entry
    logic       res_load;
    logic       res_status;
    logic       res_lookup;
    logic       res_hit;
  } dp_cmd_t;

  typedef struct packed {
    logic       start_ge;    // start of read entry >= captured start
    logic       start_ne;    // start of read entry != captured start
    logic       in_range;    // lookup address inside read entry
  } dp_sts_t;

  function automatic logic [7:0] make_attr(input logic [1:0] mtype, input logic [2:0] pol);
    logic [7:0] a;
    unique case (mtype)
      2'd0:    a = 8'hDF;
      2'd1:    a = 8'h2B;
      2'd2:    a = 8'h23;
      default: a = 8'h00;
    endcase
    if (pol == PolWriteBack || pol == PolWriteThru) begin
      a = a | CacheBits;
    end else if (pol <= PolUncacheable) begin
      a = a & ~CacheBits;
    end
    return a;
  endfunction

endpackage

FILE: hdl/pmarc_dp.sv
// Datapath of the PMA region checker: region table, comparators, result register.
// Depends on pmarc_pkg.
module pmarc_dp #(
  parameter int unsigned MaxRegions = pmarc_pkg::MaxRegionsDefault,
  parameter int unsigned IdxW       = (MaxRegions > 1) ? $clog2(MaxRegions) : 1
) (
  input  logic               clk_i,
  input  logic [31:0]        region_start_i,
  input  logic [31:0]        region_end_i,
  input  logic [1:0]         mem_type_i,
  input  logic [2:0]         policy_in_i,
  input  logic [31:0]        lookup_addr_i,
  input  logic [IdxW-1:0]    rd_idx_i,
  input  logic [IdxW-1:0]    wr_idx_i,
  input  pmarc_pkg::dp_cmd_t cmd_i,
  output pmarc_pkg::dp_sts_t sts_o,
  output logic               status_o,
  output logic               hit_o,
  output logic [7:0]         attr_o,
  output logic [1:0]         type_out_o,
  output logic [2:0]         policy_out_o
);

  logic [31:0] start_mem [MaxRegions];
  logic [31:0] end_mem   [MaxRegions];
  logic [7:0]  attr_mem  [MaxRegions];

  logic [31:0] start_q, end_q, addr_q;
  logic [7:0]  new_attr_q;
  logic        status_q, hit_q, lookup_q;
  logic [7:0]  attr_q;

  // Table read data, registered: an entry addressed in a cycle is seen in the next.
  logic [31:0] rd_start_q, rd_end_q;
  logic [7:0]  rd_attr_q;

  always_ff @(posedge clk_i) begin
    rd_start_q <= start_mem[rd_idx_i];
    rd_end_q   <= end_mem[rd_idx_i];
    rd_attr_q  <= attr_mem[rd_idx_i];
    if (cmd_i.cap) begin
      start_q    <= region_start_i;
      end_q      <= region_end_i;
      addr_q     <= lookup_addr_i;
      new_attr_q <= pmarc_pkg::make_attr(mem_type_i, policy_in_i);
    end
    if (cmd_i.wr_en) begin
      start_mem[wr_idx_i] <= cmd_i.wr_new ? start_q    : rd_start_q;
      end_mem[wr_idx_i]   <= cmd_i.wr_new ? end_q      : rd_end_q;
      attr_mem[wr_idx_i]  <= cmd_i.wr_new ? new_attr_q : rd_attr_q;
    end
    if (cmd_i.res_load) begin
      status_q <= cmd_i.res_status;
      lookup_q <= cmd_i.res_lookup;
      hit_q    <= cmd_i.res_hit;
      attr_q   <= rd_attr_q;
    end
  end

  assign sts_o.start_ge = rd_start_q >= start_q;
  assign sts_o.start_ne = rd_start_q != start_q;
  assign sts_o.in_range = (addr_q >= rd_start_q) && (addr_q <= rd_end_q);

  always_comb begin
    status_o     = status_q;
    hit_o        = lookup_q & hit_q;
    attr_o       = 8'h00;
    type_out_o   = pmarc_pkg::TypeNormal;
    policy_out_o = pmarc_pkg::PolWriteBack;
    if (lookup_q && !hit_q) begin
      type_out_o   = pmarc_pkg::TypeReserved;
      policy_out_o = pmarc_pkg::PolUncacheable;
    end else if (lookup_q) begin
      attr_o = attr_q;
      if (attr_q[pmarc_pkg::AttrD]) begin
        type_out_o = attr_q[pmarc_pkg::AttrW] ? pmarc_pkg::TypeDevice : pmarc_pkg::TypeReserved;
      end
      if (!attr_q[pmarc_pkg::AttrC]) begin
        policy_out_o = pmarc_pkg::PolUncacheable;
      end else if (attr_q[pmarc_pkg::AttrD]) begin
        policy_out_o = pmarc_pkg::PolUncached;
      end
    end
  end

endmodule

FILE: hdl/pmarc_ctrl.sv
// Controller of the PMA region checker: request sequencer, table pointers, count.
// Depends on pmarc_pkg.
module pmarc_ctrl #(
  parameter int unsigned MaxRegions = pmarc_pkg::MaxRegionsDefault,
  parameter int unsigned IdxW       = (MaxRegions > 1) ? $clog2(MaxRegions) : 1,
  parameter int unsigned CntW       = $clog2(MaxRegions + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [1:0]         req_type_i,
  output logic [IdxW-1:0]    rd_idx_o,
  output logic [IdxW-1:0]    wr_idx_o,
  output pmarc_pkg::dp_cmd_t cmd_o,
  input  pmarc_pkg::dp_sts_t sts_i
);

  localparam logic [CntW-1:0] Full = CntW'(MaxRegions);

  pmarc_pkg::state_e state_q, state_d;
  logic [CntW-1:0] ptr_q, ptr_d, wptr_q, wptr_d, count_q, count_d;
  logic [CntW-1:0] ptr_m1, ptr_m2, ptr_p1, count_m1;

  assign ptr_m1   = ptr_q - 1'b1;
  assign ptr_m2   = ptr_q - 2'd2;
  assign ptr_p1   = ptr_q + 1'b1;
  assign count_m1 = count_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pmarc_pkg::ST_IDLE;
      ptr_q   <= '0;
      wptr_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      wptr_q  <= wptr_d;
      count_q <= count_d;
    end
  end

  // The table read is registered, so each entry is addressed in the cycle before it is wanted.
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    wptr_d      = wptr_q;
    count_d     = count_q;
    cmd_o       = '0;
    rd_idx_o    = IdxW'(ptr_p1);
    wr_idx_o    = IdxW'(ptr_q);
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      pmarc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        rd_idx_o   = '0;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          ptr_d     = '0;
          wptr_d    = '0;
          unique case (pmarc_pkg::req_e'(req_type_i))
            pmarc_pkg::REQ_ADD: begin
              if (count_q >= Full) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = 1'b1;
                state_d          = pmarc_pkg::ST_DONE;
              end else begin
                rd_idx_o = IdxW'(count_m1);
                ptr_d    = count_q;
                state_d  = pmarc_pkg::ST_ADD;
              end
            end
            pmarc_pkg::REQ_REMOVE: state_d = pmarc_pkg::ST_REMOVE;
            pmarc_pkg::REQ_CLEAR: begin
              count_d        = '0;
              cmd_o.res_load = 1'b1;
              state_d        = pmarc_pkg::ST_DONE;
            end
            pmarc_pkg::REQ_LOOKUP: state_d = pmarc_pkg::ST_LOOKUP;
            default: state_d = pmarc_pkg::ST_IDLE;
          endcase
        end
      end
      pmarc_pkg::ST_ADD: begin
        // Walk down from the end, moving entries up until the slot is found.
        rd_idx_o     = IdxW'(ptr_m2);
        cmd_o.wr_en  = 1'b1;
        if (ptr_q == '0 || !sts_i.start_ge) begin
          cmd_o.wr_new   = 1'b1;
          cmd_o.res_load = 1'b1;
          count_d        = count_q + 1'b1;
          state_d        = pmarc_pkg::ST_DONE;
        end else begin
          ptr_d = ptr_m1;
        end
      end
      pmarc_pkg::ST_REMOVE: begin
        wr_idx_o = IdxW'(wptr_q);
        if (ptr_q == count_q) begin
          count_d        = wptr_q;
          cmd_o.res_load = 1'b1;
          state_d        = pmarc_pkg::ST_DONE;
        end else begin
          if (sts_i.start_ne) begin
            cmd_o.wr_en = 1'b1;
            wptr_d      = wptr_q + 1'b1;
          end
          ptr_d = ptr_p1;
        end
      end
      pmarc_pkg::ST_LOOKUP: begin
        cmd_o.res_lookup = 1'b1;
        if (ptr_q == count_q) begin
          cmd_o.res_load = 1'b1;
          state_d        = pmarc_pkg::ST_DONE;
        end else if (sts_i.in_range) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_hit  = 1'b1;
          state_d        = pmarc_pkg::ST_DONE;
        end else begin
          ptr_d = ptr_p1;
        end
      end
      pmarc_pkg::ST_DONE: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = pmarc_pkg::ST_IDLE;
        end
      end
      default: state_d = pmarc_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/pma_region_checker_top.sv
// Top level of the PMA region checker: joins controller and datapath.
// Depends on pmarc_pkg, pmarc_ctrl and pmarc_dp.
//
// Usage: one request item enters on the input channel (in_valid_i with in_stall_o
// driven by this block) and exactly one result item leaves on the output channel
// (out_valid_o with out_stall_i driven by the receiver).
// Requests: add a region, remove all regions with a given start, clear, or look up an
// address. The table holds up to MaxRegions regions in start order.
// Clear and a full-table add go straight to the result; an add walks down from the end,
// shifting entries up until its slot is found; a remove walks every entry; a lookup
// walks the entries up to the first hit, or all of them on a miss. The controller walks
// the table through the single read port, one entry per cycle.
// One item is worked on at a time: in_stall_o is low only while the block is idle.
// Reset empties the table (the region count goes to zero) and drops any pending item.
// While the receiver stalls, the result is held stable and no new item is taken.
module pma_region_checker_top #(
  parameter int unsigned MaxRegions = pmarc_pkg::MaxRegionsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] region_start_i,
  input  logic [31:0] region_end_i,
  input  logic [1:0]  mem_type_i,
  input  logic [2:0]  policy_in_i,
  input  logic [31:0] lookup_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic        hit_o,
  output logic        readable_o,
  output logic        writable_o,
  output logic        executable_o,
  output logic        atomic_ok_o,
  output logic        cacheable_o,
  output logic        device_memory_o,
  output logic        icache_ok_o,
  output logic        dcache_ok_o,
  output logic [1:0]  type_out_o,
  output logic [2:0]  policy_out_o
);

  localparam int unsigned IdxW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;

  logic [IdxW-1:0]    rd_idx, wr_idx;
  pmarc_pkg::dp_cmd_t cmd;
  pmarc_pkg::dp_sts_t sts;
  logic [7:0]         attr;

  pmarc_ctrl #(.MaxRegions(MaxRegions)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .req_type_i  (req_type_i),
    .rd_idx_o    (rd_idx),
    .wr_idx_o    (wr_idx),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pmarc_dp #(.MaxRegions(MaxRegions)) u_dp (
    .clk_i          (clk_i),
    .region_start_i (region_start_i),
    .region_end_i   (region_end_i),
    .mem_type_i     (mem_type_i),
    .policy_in_i    (policy_in_i),
    .lookup_addr_i  (lookup_addr_i),
    .rd_idx_i       (rd_idx),
    .wr_idx_i       (wr_idx),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status_o),
    .hit_o          (hit_o),
    .attr_o         (attr),
    .type_out_o     (type_out_o),
    .policy_out_o   (policy_out_o)
  );

  // Attribute bits fan out to their own result fields.
  assign readable_o      = attr[pmarc_pkg::AttrR];
  assign writable_o      = attr[pmarc_pkg::AttrW];
  assign executable_o    = attr[pmarc_pkg::AttrX];
  assign atomic_ok_o     = attr[pmarc_pkg::AttrA];
  assign cacheable_o     = attr[pmarc_pkg::AttrC];
  assign device_memory_o = attr[pmarc_pkg::AttrD];
  assign icache_ok_o     = attr[pmarc_pkg::AttrIc];
  assign dcache_ok_o     = attr[pmarc_pkg::AttrDc];

endmodule

FILE: hdl/pmarc_checker.sv
// Port-level assertions for the PMA region checker and the bind that attaches them.
// Depends on pma_region_checker_top.
module pmarc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       status_o,
  input logic       hit_o,
  input logic       readable_o,
  input logic [1:0] type_out_o,
  input logic [2:0] policy_out_o
);

  // Only one item is in flight: a pending result keeps the input stalled.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open while result pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("accepted twice in a row");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o) && $stable(hit_o)))
    else $error("stalled result changed");

  a_nohit_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (!readable_o &&
      ((type_out_o == 2'd0 && policy_out_o == 3'd0) ||
       (type_out_o == 2'd3 && policy_out_o == 3'd4))))
    else $error("bad result for non-hit item");

endmodule

bind pma_region_checker_top pmarc_checker u_pmarc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .hit_o        (hit_o),
  .readable_o   (readable_o),
  .type_out_o   (type_out_o),
  .policy_out_o (policy_out_o)
);

FILE: tb/testbench.sv
// Testbench for pma_region_checker_top: directed and random region requests
// checked against a built-in model of the region table. Depends on pmarc_pkg.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NumRegions = 16;
  localparam int unsigned RandItems  = 1520;
  localparam int unsigned IdleLimit  = 20000;

  // One result item, with the fields in port order.
  typedef struct packed {
    logic       status;
    logic       hit;
    logic [7:0] attr;   // bit 0 readable ... bit 7 dcache_ok
    logic [1:0] type_out;
    logic [2:0] policy_out;
  } pma_result_t;

  // The region table model and the queue of results it predicts.
  class pma_table_board;
    logic [31:0] start_tab[NumRegions];
    logic [31:0] end_tab[NumRegions];
    logic [7:0]  attr_tab[NumRegions];
    int unsigned count;
    pma_result_t pending[$];
    int unsigned errors;

    function logic [7:0] attr_of(logic [1:0] mtype, logic [2:0] pol);
      logic [7:0] a;
      case (mtype)
        2'd0:    a = 8'b1101_1111;
        2'd1:    a = 8'b0010_1011;
        2'd2:    a = 8'b0010_0011;
        default: a = 8'b0000_0000;
      endcase
      if (pol <= 3'd1) a = a | 8'b1101_0000;
      else if (pol <= 3'd4) a = a & 8'b0010_1111;
      return a;
    endfunction

    function void note_request(pmarc_pkg::req_e req, logic [31:0] rs, logic [31:0] re,
                               logic [1:0] mtype, logic [2:0] pol, logic [31:0] la);
      pma_result_t r;
      int unsigned i, w;
      logic found;
      logic [7:0] a;
      r = '0;
      case (req)
        pmarc_pkg::REQ_ADD: begin
          if (count >= NumRegions) begin
            r.status = 1'b1;
          end else begin
            i = 0;
            while (i < count && start_tab[i] < rs) i++;
            for (w = count; w > i; w--) begin
              start_tab[w] = start_tab[w-1];
              end_tab[w]   = end_tab[w-1];
              attr_tab[w]  = attr_tab[w-1];
            end
            start_tab[i] = rs;
            end_tab[i]   = re;
            attr_tab[i]  = attr_of(mtype, pol);
            count++;
          end
        end
        pmarc_pkg::REQ_REMOVE: begin
          w = 0;
          for (i = 0; i < count; i++) begin
            if (start_tab[i] != rs) begin
              start_tab[w] = start_tab[i];
              end_tab[w]   = end_tab[i];
              attr_tab[w]  = attr_tab[i];
              w++;
            end
          end
          count = w;
        end
        pmarc_pkg::REQ_CLEAR: count = 0;
        default: begin
          found = 1'b0;
          a = '0;
          for (i = 0; i < count && !found; i++) begin
            if (la >= start_tab[i] && la <= end_tab[i]) begin
              found = 1'b1;
              a = attr_tab[i];
            end
          end
          r.hit  = found;
          r.attr = a;
          // A device region reports device type only when it is writable.
          r.type_out = !found ? pmarc_pkg::TypeReserved :
                       a[pmarc_pkg::AttrD] ? (a[pmarc_pkg::AttrW] ? pmarc_pkg::TypeDevice
                                                                  : pmarc_pkg::TypeReserved)
                                           : pmarc_pkg::TypeNormal;
          r.policy_out = !a[pmarc_pkg::AttrC] ? pmarc_pkg::PolUncacheable :
                         a[pmarc_pkg::AttrD] ? pmarc_pkg::PolUncached : pmarc_pkg::PolWriteBack;
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(pma_result_t got);
      pma_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status expected %b actual %b", $time, exp.status, got.status);
        errors++;
      end
      if (got.hit !== exp.hit) begin
        $display("%0t: hit expected %b actual %b", $time, exp.hit, got.hit);
        errors++;
      end
      if (got.attr !== exp.attr) begin
        $display("%0t: attributes expected %b actual %b", $time, exp.attr, got.attr);
        errors++;
      end
      if (got.type_out !== exp.type_out) begin
        $display("%0t: type expected %0d actual %0d", $time, exp.type_out, got.type_out);
        errors++;
      end
      if (got.policy_out !== exp.policy_out) begin
        $display("%0t: policy expected %0d actual %0d", $time, exp.policy_out,
                 got.policy_out);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = '0;
  logic [31:0] region_start_i = '0;
  logic [31:0] region_end_i = '0;
  logic [1:0]  mem_type_i = '0;
  logic [2:0]  policy_in_i = '0;
  logic [31:0] lookup_addr_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        status_o, hit_o, readable_o, writable_o, executable_o, atomic_ok_o;
  logic        cacheable_o, device_memory_o, icache_ok_o, dcache_ok_o;
  logic [1:0]  type_out_o;
  logic [2:0]  policy_out_o;

  pma_region_checker_top u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  pma_table_board board = new();
  logic        feed_done = 1'b0;
  int unsigned idle_cycles = 0;
  // Region starts drawn from this small pool so that adds collide, removes hit
  // and lookups land inside stored regions.
  logic [31:0] start_pool[8];

  // Gap lengths: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_item(pmarc_pkg::req_e req, logic [31:0] rs, logic [31:0] re,
                           logic [1:0] mtype, logic [2:0] pol, logic [31:0] la);
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    region_start_i <= rs;
    region_end_i   <= re;
    mem_type_i     <= mtype;
    policy_in_i    <= pol;
    lookup_addr_i  <= la;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(req, rs, re, mtype, pol, la);
  endtask

  // Send one item, then drop valid for a random gap (or keep it up for the next).
  task automatic send_gapped(pmarc_pkg::req_e req, logic [31:0] rs, logic [31:0] re,
                             logic [1:0] mtype, logic [2:0] pol, logic [31:0] la);
    int unsigned g;
    send_item(req, rs, re, mtype, pol, la);
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  // Random item: mostly adds and lookups over the pool, with some noise.
  task automatic random_item();
    int unsigned p;
    logic [31:0] s, e, a;
    p = $urandom_range(99);
    s = ($urandom_range(3) == 0) ? $urandom() : start_pool[$urandom_range(7)];
    e = ($urandom_range(9) == 0) ? $urandom() : s + $urandom_range(0, 32'h3000);
    a = ($urandom_range(4) == 0) ? $urandom() : start_pool[$urandom_range(7)] +
                                                $urandom_range(0, 32'h3000);
    if (p < 40) begin
      send_gapped(pmarc_pkg::REQ_ADD, s, e, 2'($urandom_range(3)), 3'($urandom_range(7)),
                  $urandom());
    end else if (p < 52) begin
      send_gapped(pmarc_pkg::REQ_REMOVE, s, $urandom(), 2'($urandom_range(3)),
                  3'($urandom_range(7)), $urandom());
    end else if (p < 55) begin
      send_gapped(pmarc_pkg::REQ_CLEAR, $urandom(), $urandom(), 2'($urandom_range(3)),
                  3'($urandom_range(7)), $urandom());
    end else begin
      send_gapped(pmarc_pkg::REQ_LOOKUP, $urandom(), $urandom(), 2'($urandom_range(3)),
                  3'($urandom_range(7)), a);
    end
  endtask

  // Receiver: stall at random, check each result as it is taken.
  always @(posedge clk_i) begin
    pma_result_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {status_o, hit_o, dcache_ok_o, icache_ok_o, device_memory_o, cacheable_o,
               atomic_ok_o, executable_o, writable_o, readable_o, type_out_o, policy_out_o};
        board.check_result(got);
      end
      out_stall_i <= (gap_len() != 0) && ($urandom_range(2) == 0);
    end
  end

  // Watchdog: cycles without any accepted item on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    for (k = 0; k < 8; k++) start_pool[k] = {4'($urandom_range(15)), 28'h0} + k * 32'h1000;
    start_pool[0] = 32'h0;
    start_pool[7] = 32'hFFFF_F000;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty-table lookup, extremes, every type and policy,
    // an inverted region, duplicate starts, a full table and its overflow.
    send_gapped(pmarc_pkg::REQ_LOOKUP, '0, '0, 2'd0, 3'd0, 32'h0);
    send_gapped(pmarc_pkg::REQ_ADD, 32'h0, 32'hFFFF_FFFF, 2'd3, 3'd7, '0);
    send_gapped(pmarc_pkg::REQ_ADD, 32'h0, 32'h0000_0FFF, 2'd0, 3'd0, '0);
    send_gapped(pmarc_pkg::REQ_LOOKUP, '0, '0, 2'd0, 3'd0, 32'h0);
    send_gapped(pmarc_pkg::REQ_LOOKUP, '0, '0, 2'd0, 3'd0, 32'hFFFF_FFFF);
    send_gapped(pmarc_pkg::REQ_ADD, 32'h9000, 32'h8000, 2'd1, 3'd1, '0);
    send_gapped(pmarc_pkg::REQ_LOOKUP, '0, '0, 2'd0, 3'd0, 32'h8800);
    send_gapped(pmarc_pkg::REQ_REMOVE, 32'h0, '0, 2'd0, 3'd0, '0);
    send_gapped(pmarc_pkg::REQ_LOOKUP, '0, '0, 2'd0, 3'd0, 32'h10);
    for (k = 0; k < 16; k++) begin
      send_gapped(pmarc_pkg::REQ_ADD, 32'h1000 * (k % 5), 32'h1000 * (k % 5) + 32'hFFF,
                  2'(k % 4), 3'(k % 8), '0);
    end
    send_gapped(pmarc_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd2, 3'd2, '0);
    for (k = 0; k < 5; k++) begin
      send_gapped(pmarc_pkg::REQ_LOOKUP, '0, '0, 2'd0, 3'd0, 32'h1000 * k + 5);
    end
    send_gapped(pmarc_pkg::REQ_REMOVE, 32'h2000, '0, 2'd0, 3'd0, '0);
    send_gapped(pmarc_pkg::REQ_LOOKUP, '0, '0, 2'd0, 3'd0, 32'h2005);
    send_gapped(pmarc_pkg::REQ_CLEAR, '1, '1, 2'd3, 3'd7, '1);
    send_gapped(pmarc_pkg::REQ_LOOKUP, '0, '0, 2'd0, 3'd0, 32'h1005);

    // The sender holds off until every result is back, once here.
    wait_drained();

    for (k = 0; k < RandItems; k++) begin
      random_item();
      if (k == RandItems / 2) wait_drained();
    end
    in_valid_i <= 1'b0;
    feed_done  <= 1'b1;
  end

  // End of run: wait for the last results, then let the block settle.
  initial begin
    wait (feed_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
